FILE: rtl/core/qas_pkg.sv
// Package for the quoted argument splitter: result codes, quote codes,
// the result record and the byte constants of the command line syntax.
// No dependencies.
package qas_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_END      = 2'd1,
        KIND_OK       = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        logic [7:0] arg_number;
        logic       last;
    } t_result;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    localparam logic [7:0] MAX_ARGS_RESET = 8'd127;

endpackage

FILE: rtl/core/qas_if.sv
// Valid/ready channel interfaces of the quoted argument splitter: one for
// input bytes and one for result beats. No dependencies.
interface qas_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface qas_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [7:0] arg_number;
    logic       last;

    modport source (output valid, output kind, output char_out, output arg_number,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_out, input arg_number,
                    input last, output ready);
endinterface

FILE: rtl/core/quoted_argument_splitter.sv
// Top level of the quoted argument splitter: parser state, result queue and
// the max_args register. Depends on qas_pkg and the channels in qas_if.sv.
//
// The block takes a command line one byte per beat on i_char and splits it
// into arguments, delivering argument bytes, end-of-argument marks and one
// line status beat per line on o_res. Blanks and tabs outside quotes separate
// arguments, a backslash makes the next byte literal, and a single or double
// quote opens a span that only the same quote closes. A NUL or newline ends
// the line; the status is overflow once the argument count reaches the
// smaller of max_args and ARG_LIMIT, and the rest of that line is dropped.
// Each byte is parsed in the cycle it is accepted and its results are written
// straight into a two-entry result queue, so one byte is taken every cycle
// while o_res keeps up. A line end that closes an open argument produces two
// beats, and the input then holds off while the queue drains.
// Bytes that open, close or escape produce no beat at all.
module quoted_argument_splitter #(
    parameter int unsigned ARG_LIMIT = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_max_args_we,
    input  logic [7:0]  i_max_args_data,
    qas_char_if.sink    i_char,
    qas_res_if.source   o_res
);
    import qas_pkg::*;

    // The argument count never needs more than eight bits: the limit is
    // capped by the eight bit max_args register.
    localparam logic [7:0] LIM_CAP = (ARG_LIMIT > 255) ? 8'hFF : 8'(ARG_LIMIT);

    logic [7:0] r_max_args;
    logic       r_in_arg,  n_in_arg;
    t_quote     r_quote,   n_quote;
    logic       r_esc,     n_esc;
    logic [7:0] r_count,   n_count;
    logic       r_ovf,     n_ovf;

    // Result queue: slot 0 is the head shown on o_res.
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic [1:0] r_q_cnt, n_q_cnt;

    t_result    res0, res1;
    logic [1:0] res_num;
    logic [7:0] lim;
    logic       pop, accept;

    assign lim = (r_max_args < LIM_CAP) ? r_max_args : LIM_CAP;

    assign pop    = (r_q_cnt != 2'd0) && o_res.ready;
    // A byte can add two beats, so take it only when the queue will be empty.
    assign i_char.ready = (r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && pop);
    assign accept = i_char.valid && i_char.ready;

    assign o_res.valid      = (r_q_cnt != 2'd0);
    assign o_res.kind       = r_slot0.kind;
    assign o_res.char_out   = r_slot0.char_out;
    assign o_res.arg_number = r_slot0.arg_number;
    assign o_res.last       = r_slot0.last;

    // Parser: next state and the results of the byte on i_char.
    always_comb begin
        logic [7:0] c;
        logic       blank;
        logic       go;
        logic [7:0] cnt;
        t_quote     quote;
        logic       esc;
        t_quote     q;
        t_kind      status;

        c      = i_char.char_in;
        blank  = (c == CH_SPACE) || (c == CH_TAB);
        go     = 1'b1;
        cnt    = r_count;
        quote  = r_quote;
        esc    = r_esc;
        q      = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
        status = (r_ovf || (r_count >= lim)) ? KIND_OVERFLOW : KIND_OK;

        n_in_arg = r_in_arg;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_count  = r_count;
        n_ovf    = r_ovf;
        res_num  = 2'd0;
        res0     = '{kind: KIND_BYTE, char_out: c, arg_number: r_count - 8'd1,
                     last: 1'b1};
        res1     = '{kind: status, char_out: 8'd0, arg_number: r_count, last: 1'b1};

        if ((c == CH_NUL) || (c == CH_NL)) begin
            // The open argument gets its end mark ahead of the line status.
            if (r_in_arg) begin
                res0    = '{kind: KIND_END, char_out: 8'd0,
                            arg_number: r_count - 8'd1, last: 1'b0};
                res_num = 2'd2;
            end else begin
                res0    = res1;
                res_num = 2'd1;
            end
            n_in_arg = 1'b0;
            n_quote  = QUOTE_NONE;
            n_esc    = 1'b0;
            n_count  = 8'd0;
            n_ovf    = 1'b0;
        end else if (!r_ovf) begin
            if (!r_in_arg) begin
                if (blank) begin
                    go = 1'b0;
                end else if (r_count >= lim) begin
                    // No room for another argument: drop the rest of the line.
                    n_ovf = 1'b1;
                    go    = 1'b0;
                end else begin
                    cnt   = r_count + 8'd1;
                    quote = QUOTE_NONE;
                    esc   = 1'b0;
                end
            end
            if (go) begin
                n_in_arg = 1'b1;
                n_count  = cnt;
                n_quote  = quote;
                n_esc    = esc;
                res0.arg_number = cnt - 8'd1;
                if (esc) begin
                    n_esc   = 1'b0;
                    res_num = 2'd1;
                end else if ((quote == QUOTE_NONE) && blank) begin
                    n_in_arg = 1'b0;
                    if (cnt >= lim) begin
                        n_ovf = 1'b1;
                    end
                    res0.kind     = KIND_END;
                    res0.char_out = 8'd0;
                    res_num       = 2'd1;
                end else if (c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                    if (quote == q) begin
                        n_quote = QUOTE_NONE;
                    end else if (quote == QUOTE_NONE) begin
                        n_quote = q;
                    end else begin
                        // The other quote kind is copied inside a span.
                        res_num = 2'd1;
                    end
                end else begin
                    res_num = 2'd1;
                end
            end
        end
    end

    // Queue update: pop the head first, then append the new results in order.
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_q_cnt = r_q_cnt;
        if (pop) begin
            n_slot0 = r_slot1;
            n_q_cnt = r_q_cnt - 2'd1;
        end
        if (accept && (res_num != 2'd0)) begin
            if (n_q_cnt == 2'd0) begin
                n_slot0 = res0;
            end else begin
                n_slot1 = res0;
            end
            n_q_cnt = n_q_cnt + 2'd1;
            if (res_num == 2'd2) begin
                n_slot1 = res1;
                n_q_cnt = n_q_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args <= MAX_ARGS_RESET;
            r_in_arg   <= 1'b0;
            r_quote    <= QUOTE_NONE;
            r_esc      <= 1'b0;
            r_count    <= 8'd0;
            r_ovf      <= 1'b0;
            r_q_cnt    <= 2'd0;
        end else begin
            if (i_max_args_we) begin
                r_max_args <= i_max_args_data;
            end
            if (accept) begin
                r_in_arg <= n_in_arg;
                r_quote  <= n_quote;
                r_esc    <= n_esc;
                r_count  <= n_count;
                r_ovf    <= n_ovf;
            end
            r_q_cnt <= n_q_cnt;
        end
    end

    // Result payload registers carry no reset; the queue count qualifies them.
    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    // The queue holds two beats at most.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("result queue count out of range");

    // An end mark that is not the last beat of its byte is followed by the
    // line status, already waiting in the second slot.
    a_end_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_END) && !o_res.last) |->
        ((r_q_cnt == 2'd2) &&
         ((r_slot1.kind == KIND_OK) || (r_slot1.kind == KIND_OVERFLOW))))
        else $error("end mark without the line status behind it");

    // A pending escape or an open quote exists only inside an argument.
    a_span_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esc || (r_quote != QUOTE_NONE)) |-> r_in_arg)
        else $error("escape or quote state outside an argument");

endmodule
